### hdl/tpcs_pkg.sv
package tpcs_pkg;

    localparam int ID_W    = 7;
    localparam int SIZE_W  = 7;
    localparam int CH_W    = 2 * ID_W;
    localparam int SIM_W   = 24;
    localparam int SUM_W   = 40;
    localparam int SCORE_W = 24;
    localparam int PROD_W  = 2 * SIZE_W;
    localparam int CFG_W   = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_LEAF_A = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEAF_B = 1'd1;

    typedef enum logic [1:0] {
        FUNC_LOAD_A   = 2'd0,
        FUNC_LOAD_B   = 2'd1,
        FUNC_LOAD_SIM = 2'd2,
        FUNC_COMPUTE  = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_LD_L,
        S_LD_R,
        S_LD_W,
        S_SIM,
        S_CH_RD,
        S_CH_CAP,
        S_PR_RD,
        S_PR_ACC,
        S_WB,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic latch;
        logic clr_step;
        logic ld_l;
        logic ld_r;
        logic ld_w;
        logic sim_wr;
        logic ch_cap;
        logic pr_rd;
        logic pr_acc;
        logic wb;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic  in_valid;
        t_func in_func;
        logic  clr_last;
        logic  clr_done;
        logic  pair_last;
        logic  div_last;
        logic  out_free;
    } t_status;

endpackage

### hdl/tpcs_if.sv
interface tpcs_in_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   func;
    logic [tpcs_pkg::ID_W-1:0]    node_id;
    logic [tpcs_pkg::ID_W-1:0]    left_child;
    logic [tpcs_pkg::ID_W-1:0]    right_child;
    logic [tpcs_pkg::ID_W-1:0]    row_id;
    logic [tpcs_pkg::ID_W-1:0]    col_id;
    logic [tpcs_pkg::SIM_W-1:0]   similarity;

    modport source (output valid, func, node_id, left_child, right_child, row_id, col_id,
                    similarity, input ready);
    modport sink (input valid, func, node_id, left_child, right_child, row_id, col_id,
                  similarity, output ready);
endinterface

interface tpcs_out_if;
    logic                          valid;
    logic                          ready;
    logic [tpcs_pkg::SCORE_W-1:0]  score;
    logic [tpcs_pkg::SUM_W-1:0]    pair_sum;
    logic                          reportable;

    modport source (output valid, score, pair_sum, reportable, input ready);
    modport sink (input valid, score, pair_sum, reportable, output ready);
endinterface

### hdl/tpcs_ctrl.sv
module tpcs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tpcs_pkg::t_status i_st,
    output tpcs_pkg::t_cmd    o_cmd
);
    import tpcs_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (i_st.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_st.in_valid) begin
                    case (i_st.in_func)
                        FUNC_LOAD_A:   n_state = S_LD_L;
                        FUNC_LOAD_B:   n_state = S_LD_L;
                        FUNC_LOAD_SIM: n_state = S_SIM;
                        FUNC_COMPUTE:  n_state = S_CH_RD;
                        default:       n_state = S_IDLE;
                    endcase
                end
            end
            S_LD_L:   n_state = S_LD_R;
            S_LD_R:   n_state = S_LD_W;
            S_LD_W:   n_state = S_IDLE;
            S_SIM:    n_state = S_IDLE;
            S_CH_RD:  n_state = S_CH_CAP;
            S_CH_CAP: n_state = S_PR_RD;
            S_PR_RD:  n_state = S_PR_ACC;
            S_PR_ACC: begin
                n_state = i_st.pair_last ? S_WB : S_PR_RD;
            end
            S_WB:     n_state = S_DIV;
            S_DIV: begin
                if (i_st.div_last) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_st.out_free) n_state = S_IDLE;
            end
            default:  n_state = S_CLR;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_CLR:    o_cmd.clr_step = 1'b1;
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.latch    = i_st.in_valid;
            end
            S_LD_L:   o_cmd.ld_l     = 1'b1;
            S_LD_R:   o_cmd.ld_r     = 1'b1;
            S_LD_W:   o_cmd.ld_w     = 1'b1;
            S_SIM:    o_cmd.sim_wr   = 1'b1;
            S_CH_RD:  o_cmd          = '0;
            S_CH_CAP: o_cmd.ch_cap   = 1'b1;
            S_PR_RD:  o_cmd.pr_rd    = 1'b1;
            S_PR_ACC: o_cmd.pr_acc   = 1'b1;
            S_WB:     o_cmd.wb       = 1'b1;
            S_DIV:    o_cmd.div_step = 1'b1;
            S_OUT:    o_cmd.out_load = i_st.out_free;
            default:  o_cmd          = '0;
        endcase
    end

endmodule

### hdl/tpcs_dp.sv
module tpcs_dp #(
    parameter int MAX_NODES = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tpcs_pkg::t_cmd                    i_cmd,
    output tpcs_pkg::t_status                 o_st,
    input  logic                              i_cfg_we,
    input  logic [tpcs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tpcs_pkg::CFG_W-1:0]        i_cfg_data,
    tpcs_in_if.sink                           i_in,
    tpcs_out_if.source                        o_out
);
    import tpcs_pkg::*;

    localparam int NW = $clog2(MAX_NODES);
    localparam int PW = 2 * NW;
    localparam int DIV_CNT_W = $clog2(SUM_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SUM_W - 1);

    function automatic logic in_rng(input logic [ID_W-1:0] id);
        return 32'(id) < MAX_NODES;
    endfunction

    function automatic logic [NW-1:0] idx(input logic [ID_W-1:0] id);
        logic [ID_W+NW-1:0] t;
        t = (ID_W + NW)'(id);
        return t[NW-1:0];
    endfunction

    function automatic logic is_leaf(input logic [ID_W-1:0] id, input logic [CFG_W-1:0] cnt);
        return (id != '0) && (id <= cnt);
    endfunction

    function automatic logic [SIZE_W-1:0] nsize(input logic [ID_W-1:0] id,
                                                input logic [CFG_W-1:0] cnt,
                                                input logic [SIZE_W-1:0] rd);
        if (is_leaf(id, cnt)) return SIZE_W'(1);
        if (!in_rng(id)) return '0;
        return rd;
    endfunction

    // config
    logic [CFG_W-1:0] r_leaf_a, r_leaf_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leaf_a <= CFG_W'(1);
            r_leaf_b <= CFG_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_LEAF_A) r_leaf_a <= i_cfg_data;
            if (i_cfg_idx == REG_LEAF_B) r_leaf_b <= i_cfg_data;
        end
    end

    // item
    t_func              r_func;
    logic [ID_W-1:0]    r_nid, r_lc, r_rc, r_row, r_col;
    logic [SIM_W-1:0]   r_sim;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func <= t_func'(i_in.func);
            r_nid  <= i_in.node_id;
            r_lc   <= i_in.left_child;
            r_rc   <= i_in.right_child;
            r_row  <= i_in.row_id;
            r_col  <= i_in.col_id;
            r_sim  <= i_in.similarity;
        end
    end

    assign i_in.ready = i_cmd.in_ready;

    // node memories
    logic [CH_W-1:0]   mem_ch_a [MAX_NODES];
    logic [CH_W-1:0]   mem_ch_b [MAX_NODES];
    logic [SIZE_W-1:0] mem_sz_a [MAX_NODES];
    logic [SIZE_W-1:0] mem_sz_b [MAX_NODES];
    logic [CH_W-1:0]   r_ch_a_rd, r_ch_b_rd;
    logic [SIZE_W-1:0] r_sz_a_rd, r_sz_b_rd;
    logic [NW-1:0]     n_addr_a, n_addr_b;

    logic              tree_b;
    logic [CFG_W-1:0]  ld_cnt;
    logic [SIZE_W-1:0] sz_rd;
    logic              ld_ok;
    logic [SIZE_W-1:0] r_szl, szr;
    logic [SIZE_W:0]   sz_sum;
    logic [SIZE_W-1:0] sz_new;

    assign tree_b = (r_func == FUNC_LOAD_B);
    assign ld_cnt = tree_b ? r_leaf_b : r_leaf_a;
    assign sz_rd  = tree_b ? r_sz_b_rd : r_sz_a_rd;
    assign ld_ok  = in_rng(r_nid) && !is_leaf(r_nid, ld_cnt);
    assign szr    = nsize(r_rc, ld_cnt, sz_rd);
    assign sz_sum = {1'b0, r_szl} + {1'b0, szr};
    assign sz_new = sz_sum[SIZE_W] ? {SIZE_W{1'b1}} : sz_sum[SIZE_W-1:0];

    always_comb begin
        if (i_cmd.ld_l) begin
            n_addr_a = idx(r_lc);
            n_addr_b = idx(r_lc);
        end else if (i_cmd.ld_r) begin
            n_addr_a = idx(r_rc);
            n_addr_b = idx(r_rc);
        end else begin
            n_addr_a = idx(r_row);
            n_addr_b = idx(r_col);
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch_a_rd <= mem_ch_a[n_addr_a];
        r_sz_a_rd <= mem_sz_a[n_addr_a];
        r_ch_b_rd <= mem_ch_b[n_addr_b];
        r_sz_b_rd <= mem_sz_b[n_addr_b];
        if (i_cmd.ld_w && ld_ok && !tree_b) begin
            mem_ch_a[idx(r_nid)] <= {r_lc, r_rc};
            mem_sz_a[idx(r_nid)] <= sz_new;
        end
        if (i_cmd.ld_w && ld_ok && tree_b) begin
            mem_ch_b[idx(r_nid)] <= {r_lc, r_rc};
            mem_sz_b[idx(r_nid)] <= sz_new;
        end
        if (i_cmd.ld_r) r_szl <= nsize(r_lc, ld_cnt, sz_rd);
    end

    // child lists
    logic [ID_W-1:0]   r_la0, r_la1, r_lb0, r_lb1;
    logic              r_na2, r_nb2, r_i, r_j;
    logic [SIZE_W-1:0] r_sza, r_szb;
    logic              row_single, col_single;

    assign row_single = is_leaf(r_row, r_leaf_a) || !in_rng(r_row);
    assign col_single = is_leaf(r_col, r_leaf_b) || !in_rng(r_col);

    always_ff @(posedge i_clk) begin
        if (i_cmd.ch_cap) begin
            r_na2 <= !row_single;
            r_nb2 <= !col_single;
            r_la0 <= row_single ? r_row : r_ch_a_rd[CH_W-1:ID_W];
            r_la1 <= r_ch_a_rd[ID_W-1:0];
            r_lb0 <= col_single ? r_col : r_ch_b_rd[CH_W-1:ID_W];
            r_lb1 <= r_ch_b_rd[ID_W-1:0];
            r_sza <= nsize(r_row, r_leaf_a, r_sz_a_rd);
            r_szb <= nsize(r_col, r_leaf_b, r_sz_b_rd);
            r_i   <= 1'b0;
            r_j   <= 1'b0;
        end else if (i_cmd.pr_acc) begin
            if (r_nb2 && !r_j) begin
                r_j <= 1'b1;
            end else begin
                r_j <= 1'b0;
                r_i <= 1'b1;
            end
        end
    end

    // pair-sum memory
    logic [SUM_W-1:0] mem_pair [1 << PW];
    logic [SUM_W-1:0] r_pair_rd;
    logic [PW-1:0]    r_clr_addr;
    logic             r_clr_done;
    logic [ID_W-1:0]  ca, cb;
    logic             r_pr_ok;
    logic             pair_ok, sim_ok, pair_we;
    logic [PW-1:0]    pair_waddr;
    logic [SUM_W-1:0] pair_wdata, r_sum;

    assign ca      = r_i ? r_la1 : r_la0;
    assign cb      = r_j ? r_lb1 : r_lb0;
    assign pair_ok = in_rng(r_row) && in_rng(r_col);
    assign sim_ok  = pair_ok && is_leaf(r_row, r_leaf_a) && is_leaf(r_col, r_leaf_b);
    assign pair_we = i_cmd.clr_step || (i_cmd.sim_wr && sim_ok) || (i_cmd.wb && pair_ok);

    always_comb begin
        if (i_cmd.clr_step) begin
            pair_waddr = r_clr_addr;
            pair_wdata = '0;
        end else if (i_cmd.sim_wr) begin
            pair_waddr = {idx(r_row), idx(r_col)};
            pair_wdata = SUM_W'(r_sim);
        end else begin
            pair_waddr = {idx(r_row), idx(r_col)};
            pair_wdata = r_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pair_we) mem_pair[pair_waddr] <= pair_wdata;
        r_pair_rd <= mem_pair[{idx(ca), idx(cb)}];
        if (i_cmd.pr_rd) r_pr_ok <= in_rng(ca) && in_rng(cb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clr_done <= 1'b0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + PW'(1);
            if (&r_clr_addr) r_clr_done <= 1'b1;
        end
    end

    // accumulate
    logic [SUM_W:0] acc;

    assign acc = {1'b0, r_sum} + {1'b0, (r_pr_ok ? r_pair_rd : SUM_W'(0))};

    always_ff @(posedge i_clk) begin
        if (i_cmd.ch_cap) begin
            r_sum <= '0;
        end else if (i_cmd.pr_acc) begin
            r_sum <= acc[SUM_W] ? {SUM_W{1'b1}} : acc[SUM_W-1:0];
        end
    end

    // restoring divider, one quotient bit per cycle
    logic [PROD_W-1:0]    r_prod, r_rem;
    logic [SUM_W-1:0]     r_quo;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [PROD_W:0]      div_tmp;
    logic                 div_ge;

    assign div_tmp = {r_rem, r_quo[SUM_W-1]};
    assign div_ge  = div_tmp >= {1'b0, r_prod};

    always_ff @(posedge i_clk) begin
        if (i_cmd.wb) begin
            r_prod    <= PROD_W'(r_sza) * PROD_W'(r_szb);
            r_quo     <= r_sum;
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem     <= div_ge ? PROD_W'(div_tmp - {1'b0, r_prod}) : div_tmp[PROD_W-1:0];
            r_quo     <= {r_quo[SUM_W-2:0], div_ge};
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
    end

    // result register
    logic               r_out_valid;
    logic [SCORE_W-1:0] r_score, score;
    logic [SUM_W-1:0]   r_out_sum;
    logic               r_rep;

    always_comb begin
        if (r_prod == '0) begin
            score = '0;
        end else if (|r_quo[SUM_W-1:SCORE_W]) begin
            score = {SCORE_W{1'b1}};
        end else begin
            score = r_quo[SCORE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_score   <= score;
            r_out_sum <= r_sum;
            r_rep     <= (score != '0) &&
                         (!is_leaf(r_row, r_leaf_a) || !is_leaf(r_col, r_leaf_b));
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.score      = r_score;
    assign o_out.pair_sum   = r_out_sum;
    assign o_out.reportable = r_rep;

    assign o_st.in_valid  = i_in.valid;
    assign o_st.in_func   = t_func'(i_in.func);
    assign o_st.clr_last  = &r_clr_addr;
    assign o_st.clr_done  = r_clr_done;
    assign o_st.pair_last = (!r_nb2 || r_j) && (!r_na2 || r_i);
    assign o_st.div_last  = (r_div_cnt == DIV_LAST);
    assign o_st.out_free  = !r_out_valid || o_out.ready;

endmodule

### hdl/tree_pair_cluster_similarity.sv
// Average-linkage scorer for cluster pairs of two binary trees. After reset the block
// clears all 2**(2*clog2(MAX_NODES)) entries of its pair-sum memory, one entry per cycle
// (16384 at the default), accepting no beat until that pass ends; leaf counts may be
// written meanwhile. One item is processed at a time: a tree-node load reads both children
// and then writes the node, a similarity load writes one entry, and a compute item sums
// the child pairs (1 to 4), writes the sum back and runs the 40-step restoring divider.
// A finished score sits in an output register, so the next beat is taken while it waits.
module tree_pair_cluster_similarity #(
    parameter int MAX_NODES = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tpcs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tpcs_pkg::CFG_W-1:0]        i_cfg_data,
    tpcs_in_if.sink                           i_in,
    tpcs_out_if.source                        o_out
);
    import tpcs_pkg::*;

    t_cmd    cmd;
    t_status st;

    tpcs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    tpcs_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_st       (st),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .o_out      (o_out)
    );

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> st.out_free)
        else $error("result loaded over a pending beat");

    a_accept_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> st.clr_done)
        else $error("beat accepted before clear pass finished");

    a_excl_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.latch, cmd.clr_step, cmd.sim_wr, cmd.wb, cmd.div_step, cmd.out_load}))
        else $error("conflicting datapath commands");

    a_div_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.div_step && st.div_last) |=> !cmd.div_step)
        else $error("divider ran past its last step");

endmodule

### sim/tb_scoreboard.sv
`timescale 1ns / 1ps

class linkage_scoreboard;
    localparam int NODES = 128;
    localparam logic [39:0] SUM_SAT = 40'hFF_FFFF_FFFF;

    int unsigned leaves_a;
    int unsigned leaves_b;
    logic [13:0] kids_a [NODES];
    logic [13:0] kids_b [NODES];
    int unsigned span_a [NODES];
    int unsigned span_b [NODES];
    logic [39:0] sums [NODES*NODES];
    logic [23:0] score_q [$];
    logic [39:0] sum_q [$];
    logic        flag_q [$];
    int unsigned errors;

    function new();
        leaves_a = 1;
        leaves_b = 1;
        errors = 0;
        foreach (sums[k]) sums[k] = '0;
        foreach (span_a[k]) begin
            span_a[k] = 0;
            span_b[k] = 0;
            kids_a[k] = '0;
            kids_b[k] = '0;
        end
    endfunction

    function void set_leaves(bit which_b, int unsigned n);
        if (which_b) leaves_b = n;
        else leaves_a = n;
    endfunction

    function bit is_leaf(int unsigned id, int unsigned n);
        return id >= 1 && id <= n;
    endfunction

    function int unsigned span_of(int unsigned id, bit which_b);
        if (is_leaf(id, which_b ? leaves_b : leaves_a)) return 1;
        return which_b ? span_b[id] : span_a[id];
    endfunction

    function int pending();
        return score_q.size();
    endfunction

    function void note_item(logic [1:0] fn, int unsigned nid, int unsigned lc,
                            int unsigned rc, int unsigned row, int unsigned col,
                            logic [23:0] sim);
        int unsigned s, na, nb;
        int unsigned la [2];
        int unsigned lb [2];
        logic [40:0] acc;
        logic [63:0] prod, q;
        case (fn)
            tpcs_pkg::FUNC_LOAD_A, tpcs_pkg::FUNC_LOAD_B: begin
                bit wb;
                wb = (fn == tpcs_pkg::FUNC_LOAD_B);
                if (is_leaf(nid, wb ? leaves_b : leaves_a)) return;
                s = span_of(lc, wb) + span_of(rc, wb);
                if (s > 127) s = 127;
                if (wb) begin
                    kids_b[nid] = {lc[6:0], rc[6:0]};
                    span_b[nid] = s;
                end else begin
                    kids_a[nid] = {lc[6:0], rc[6:0]};
                    span_a[nid] = s;
                end
            end
            tpcs_pkg::FUNC_LOAD_SIM: begin
                if (is_leaf(row, leaves_a) && is_leaf(col, leaves_b))
                    sums[row*NODES+col] = {16'd0, sim};
            end
            default: begin
                if (is_leaf(row, leaves_a)) begin
                    na = 1; la[0] = row;
                end else begin
                    na = 2; la[0] = kids_a[row][13:7]; la[1] = kids_a[row][6:0];
                end
                if (is_leaf(col, leaves_b)) begin
                    nb = 1; lb[0] = col;
                end else begin
                    nb = 2; lb[0] = kids_b[col][13:7]; lb[1] = kids_b[col][6:0];
                end
                acc = '0;
                for (int i = 0; i < na; i++)
                    for (int j = 0; j < nb; j++) begin
                        acc = acc + sums[la[i]*NODES+lb[j]];
                        if (acc > SUM_SAT) acc = SUM_SAT;
                    end
                sums[row*NODES+col] = acc[39:0];
                prod = span_of(row, 0) * span_of(col, 1);
                q = 0;
                if (prod != 0) begin
                    q = acc / prod;
                    if (q > 64'hFF_FFFF) q = 64'hFF_FFFF;
                end
                score_q.push_back(q[23:0]);
                sum_q.push_back(acc[39:0]);
                flag_q.push_back(q != 0 && (!is_leaf(row, leaves_a) || !is_leaf(col, leaves_b)));
            end
        endcase
    endfunction

    function void check_result(logic [23:0] sc, logic [39:0] ps, logic rp);
        logic [23:0] e_sc;
        logic [39:0] e_ps;
        logic e_rp;
        if (score_q.size() == 0) begin
            $error("unexpected result beat score=%0h", sc);
            errors++;
            return;
        end
        e_sc = score_q.pop_front();
        e_ps = sum_q.pop_front();
        e_rp = flag_q.pop_front();
        if (sc !== e_sc) begin
            $error("score expected %0h actual %0h", e_sc, sc);
            errors++;
        end
        if (ps !== e_ps) begin
            $error("pair_sum expected %0h actual %0h", e_ps, ps);
            errors++;
        end
        if (rp !== e_rp) begin
            $error("reportable expected %0b actual %0b", e_rp, rp);
            errors++;
        end
    endfunction
endclass

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tpcs_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    tpcs_in_if in_ch();
    tpcs_out_if out_ch();

    tree_pair_cluster_similarity i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    linkage_scoreboard sb = new();
    int unsigned la, lb;

    always #5 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 0; in_ch.func = '0; in_ch.node_id = '0; in_ch.left_child = '0;
        in_ch.right_child = '0; in_ch.row_id = '0; in_ch.col_id = '0; in_ch.similarity = '0;
        out_ch.ready = 0;
    end

    always @(posedge i_clk)
        if (i_rst_n && in_ch.valid && in_ch.ready)
            sb.note_item(in_ch.func, in_ch.node_id, in_ch.left_child, in_ch.right_child,
                         in_ch.row_id, in_ch.col_id, in_ch.similarity);

    always @(posedge i_clk)
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.score, out_ch.pair_sum, out_ch.reportable);

    initial begin
        int w;
        @(negedge i_clk);
        forever begin
            w = $urandom_range(0, 3);
            if ($urandom_range(0, 3) == 0) w = 0;
            out_ch.ready <= (w == 0);
            @(negedge i_clk);
            if (w != 0) begin
                repeat (w - 1) @(negedge i_clk);
                out_ch.ready <= 1;
                @(negedge i_clk);
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= v[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 0;
        @(negedge i_clk);
    endtask

    // valid stays high into the next beat when no gap is drawn
    task automatic send(logic [1:0] fn, int unsigned nid, int unsigned lc, int unsigned rc,
                        int unsigned row, int unsigned col, logic [23:0] sim);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
            in_ch.valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1; in_ch.func <= fn; in_ch.node_id <= nid[6:0];
        in_ch.left_child <= lc[6:0]; in_ch.right_child <= rc[6:0];
        in_ch.row_id <= row[6:0]; in_ch.col_id <= col[6:0]; in_ch.similarity <= sim;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic set_counts(int unsigned a, int unsigned b);
        la = a; lb = b;
        write_reg(REG_LEAF_A, a); sb.set_leaves(0, a);
        write_reg(REG_LEAF_B, b); sb.set_leaves(1, b);
    endtask

    // Build random trees over the leaves (pure merge sequence), fill leaf sims,
    // then compute every pair in row-major order.
    task automatic scenario(bit wild);
        int unsigned poola [$], poolb [$];
        int unsigned nxa, nxb, x, y, k;
        logic [23:0] s;
        for (int i = 1; i <= la; i++) poola.push_back(i);
        for (int i = 1; i <= lb; i++) poolb.push_back(i);
        nxa = la + 1; nxb = lb + 1;
        while (poola.size() > 1 && nxa < 128) begin
            k = $urandom_range(0, poola.size() - 1); x = poola[k]; poola.delete(k);
            k = $urandom_range(0, poola.size() - 1); y = poola[k]; poola.delete(k);
            send(FUNC_LOAD_A, nxa, x, y, 0, 0, 24'($urandom));
            poola.push_back(nxa); nxa++;
        end
        while (poolb.size() > 1 && nxb < 128) begin
            k = $urandom_range(0, poolb.size() - 1); x = poolb[k]; poolb.delete(k);
            k = $urandom_range(0, poolb.size() - 1); y = poolb[k]; poolb.delete(k);
            send(FUNC_LOAD_B, nxb, x, y, 0, 0, 24'($urandom));
            poolb.push_back(nxb); nxb++;
        end
        for (int r = 1; r <= la; r++)
            for (int c = 1; c <= lb; c++) begin
                s = 24'($urandom);
                if ($urandom_range(0, 7) == 0) s = 24'hFFFFFF;
                if ($urandom_range(0, 7) == 0) s = 0;
                send(FUNC_LOAD_SIM, 0, 0, 0, r, c, s);
            end
        if (wild) begin
            // noise: leaf-id tree loads and non-leaf sim loads are ignored
            send(FUNC_LOAD_A, 1, 5, 9, 0, 0, 0);
            send(FUNC_LOAD_SIM, 0, 0, 0, 127, 1, 24'h123456);
        end
        for (int r = 1; r < nxa; r++)
            for (int c = 1; c < nxb; c++)
                send(FUNC_COMPUTE, $urandom, $urandom, $urandom, r, c, 24'($urandom));
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1;
        set_counts(1, 1);
        // directed: single leaves, full-scale similarities
        send(FUNC_LOAD_SIM, 0, 0, 0, 1, 1, 24'hFFFFFF);
        send(FUNC_COMPUTE, 0, 0, 0, 1, 1, 0);
        send(FUNC_LOAD_A, 1, 1, 1, 0, 0, 0);
        send(FUNC_LOAD_A, 2, 1, 1, 0, 0, 0);
        send(FUNC_LOAD_B, 2, 1, 1, 0, 0, 0);
        send(FUNC_LOAD_A, 3, 2, 2, 0, 0, 0);
        send(FUNC_COMPUTE, 0, 0, 0, 1, 2, 0);
        send(FUNC_COMPUTE, 0, 0, 0, 2, 1, 0);
        send(FUNC_COMPUTE, 0, 0, 0, 2, 2, 0);
        send(FUNC_COMPUTE, 0, 0, 0, 3, 2, 0);
        send(FUNC_COMPUTE, 0, 0, 0, 3, 1, 0);
        drain();
        set_counts(64, 64);
        send(FUNC_LOAD_SIM, 0, 0, 0, 64, 64, 24'hABCDEF);
        send(FUNC_LOAD_SIM, 0, 0, 0, 65, 64, 24'h1);
        send(FUNC_COMPUTE, 0, 0, 0, 64, 64, 0);
        send(FUNC_COMPUTE, 0, 0, 0, 1, 1, 0);
        drain();
        set_counts(2, 2); scenario(1); drain();
        set_counts(3, 4); scenario(0); drain();
        set_counts(5, 3); scenario(1); drain();
        set_counts(4, 4); scenario(0); drain();
        set_counts(7, 6); scenario(1); drain();
        set_counts(6, 7); scenario(0); drain();
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end
endmodule

### filelist.f
hdl/tpcs_pkg.sv
hdl/tpcs_if.sv
hdl/tpcs_ctrl.sv
hdl/tpcs_dp.sv
hdl/tree_pair_cluster_similarity.sv
sim/tb_scoreboard.sv
sim/tb_top.sv
